### hw/rtl/lsf_pkg.sv
// Shared types, constants and helpers for the letter-sum substring finder.
`default_nettype none
package lsf_pkg;

  localparam int unsigned TEXT_DEPTH  = 1024;
  localparam int unsigned ADDR_W      = $clog2(TEXT_DEPTH);
  localparam int unsigned LEN_W       = ADDR_W + 1;
  localparam int unsigned SUM_W       = 15;
  localparam int unsigned VAL_W       = 5;
  localparam int unsigned POS_W       = 10;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned OUT_W       = 24;
  localparam int unsigned RAM_W       = SUM_W + 1;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [CHAR_W-1:0] CH_UP_A = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z = 8'h7A;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_WORD  = 2'd1,
    OP_TEXT  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_WORD,
    CMD_TEXT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic [VAL_W-1:0]       value;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CHK
  } back_state_e;

  // Letter value: A/a = 1 .. Z/z = 26, anything else 0
  function automatic logic [VAL_W-1:0] letter_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] off;
    off = '0;
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      off = c - CH_UP_A + 8'd1;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      off = c - CH_LO_A + 8'd1;
    end
    return off[VAL_W-1:0];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/lsf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module lsf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire [WIDTH-1:0]           wdata_i,
  input  wire                       re_i,
  input  wire [$clog2(DEPTH)-1:0]   raddr_i,
  output logic [WIDTH-1:0]          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lsf_front.sv
// Front end: takes input transactions, decodes the opcode and letter value.
`default_nettype none
module lsf_front (
  input  wire                          s_valid_i,
  output logic                         s_ready_o,
  input  wire [lsf_pkg::OP_W-1:0]      opcode_i,
  input  wire [lsf_pkg::CHAR_W-1:0]    char_code_i,
  output logic                         cmd_valid_o,
  input  wire                          cmd_ready_i,
  output lsf_pkg::cmd_t                cmd_o
);
  import lsf_pkg::*;

  opcode_e op;

  assign op        = opcode_e'(opcode_i);
  // unused opcode is accepted and dropped
  assign s_ready_o = cmd_ready_i;

  always_comb begin
    cmd_o.value = letter_value(char_code_i);
    cmd_o.kind  = CMD_CLEAR;
    cmd_valid_o = 1'b0;
    case (op)
      OP_CLEAR: begin
        cmd_o.kind  = CMD_CLEAR;
        cmd_valid_o = s_valid_i;
      end
      OP_WORD: begin
        cmd_o.kind  = CMD_WORD;
        cmd_valid_o = s_valid_i;
      end
      OP_TEXT: begin
        cmd_o.kind  = CMD_TEXT;
        cmd_valid_o = s_valid_i;
      end
      default: begin
        cmd_valid_o = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/lsf_fifo.sv
// Short command queue between the front end and the back end.
`default_nettype none
module lsf_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_valid_i,
  output logic                push_ready_o,
  input  lsf_pkg::cmd_t       push_data_i,
  output logic                pop_valid_o,
  input  wire                 pop_ready_i,
  output lsf_pkg::cmd_t       pop_data_o
);
  import lsf_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lsf_back.sv
// Back end: target and prefix-sum bookkeeping, start-pointer scan, result register.
`default_nettype none
module lsf_back (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cmd_valid_i,
  output logic                         cmd_ready_o,
  input  lsf_pkg::cmd_t                cmd_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [lsf_pkg::POS_W-1:0]    out_start_o,
  output logic [lsf_pkg::POS_W-1:0]    out_end_o
);
  import lsf_pkg::*;

  back_state_e       state_q, state_d;
  logic [SUM_W-1:0]  target_q, running_q;
  logic [LEN_W-1:0]  len_q, oldest_q;
  logic [ADDR_W-1:0] pos_q;
  logic              pflag_q;
  logic              out_valid_q;
  logic [POS_W-1:0]  out_start_q, out_end_q;

  logic              pop, full, cmd_flag;
  logic [RAM_W-1:0]  ram_wdata, ram_rdata;
  logic              ram_we, ram_re;
  logic [SUM_W-1:0]  rd_pre, diff;
  logic              rd_flag;
  logic              have_start, skip, is_match, slot_free;
  logic              load_out, adv_start, text_go;
  logic [SUM_W:0]    target_sum_w;

  assign pop          = cmd_valid_i && cmd_ready_o;
  assign full         = (len_q >= LEN_W'(TEXT_DEPTH));
  assign cmd_flag     = (cmd_i.value != '0);
  assign ram_wdata    = {cmd_flag, running_q};
  assign rd_flag      = ram_rdata[SUM_W];
  assign rd_pre       = ram_rdata[SUM_W-1:0];
  assign diff         = running_q - rd_pre;
  assign have_start   = (oldest_q < len_q);
  assign skip         = !rd_flag || (diff > target_q);
  assign is_match     = pflag_q && (diff == target_q);
  assign slot_free    = !out_valid_q || out_ready_i;
  assign text_go      = pop && (cmd_i.kind == CMD_TEXT) && !full;
  assign target_sum_w = {1'b0, target_q} + (SUM_W + 1)'(cmd_i.value);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (text_go) begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        state_d = have_start ? ST_SCAN_CHK : ST_IDLE;
      end
      ST_SCAN_CHK: begin
        if (skip) begin
          state_d = ST_SCAN_RD;
        end else if (!is_match || slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control strobes
  always_comb begin
    cmd_ready_o = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    load_out    = 1'b0;
    adv_start   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        ram_we      = text_go;
      end
      ST_SCAN_RD: begin
        ram_re = have_start;
      end
      ST_SCAN_CHK: begin
        if (skip) begin
          adv_start = 1'b1;
        end else if (is_match && slot_free) begin
          load_out  = 1'b1;
          adv_start = 1'b1;
        end
      end
      default: begin
        cmd_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      target_q    <= '0;
      running_q   <= '0;
      len_q       <= '0;
      oldest_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (adv_start) begin
        oldest_q <= oldest_q + 1'b1;
      end
      if (pop) begin
        case (cmd_i.kind)
          CMD_CLEAR: begin
            target_q  <= '0;
            running_q <= '0;
            len_q     <= '0;
            oldest_q  <= '0;
          end
          CMD_WORD: begin
            // saturate: a saturated target can never be met by the text
            target_q <= (target_sum_w > (SUM_W + 1)'(SUM_MAX)) ?
                        SUM_MAX : target_sum_w[SUM_W-1:0];
          end
          CMD_TEXT: begin
            if (!full) begin
              running_q <= running_q + SUM_W'(cmd_i.value);
              len_q     <= len_q + 1'b1;
            end
          end
          default: begin
            len_q <= len_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_go) begin
      pos_q   <= len_q[ADDR_W-1:0];
      pflag_q <= cmd_flag;
    end
    if (load_out) begin
      out_start_q <= POS_W'(oldest_q[ADDR_W-1:0]);
      out_end_q   <= POS_W'(pos_q);
    end
  end

  lsf_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TEXT_DEPTH)
  ) u_prefix_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (len_q[ADDR_W-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (oldest_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_start_o = out_start_q;
  assign out_end_o   = out_end_q;

endmodule
`default_nettype wire

### hw/rtl/letter_sum_substring_finder.sv
// Top level of the letter-sum substring finder.
// Opcode clear resets the target, the text and all start tracking; word bytes add their letter
// value (A/a = 1 .. Z/z = 26, others 0) to a saturating target; text bytes are stored with
// their prefix sum, and each text byte may produce one transaction with the start and end
// positions of the shortest letter-bounded substring whose letter sum equals the target,
// in start order. Text bytes past 1024 are ignored. Input transactions go into a two-entry
// command queue and are taken whenever it has room. In the back end a clear, a word byte or
// a text byte past the end of the buffer is taken in the idle state; a stored text byte starts
// a scan that steps through the open start positions, each by a registered read of the
// prefix-sum RAM (ST_SCAN_RD) and a check (ST_SCAN_CHK), until it runs out of open starts or
// stops on one, and a match waits for the output register to drain; the scan steps amortize
// to about one per text byte. The prefix RAM needs no clearing pass after reset.
`default_nettype none
module letter_sum_substring_finder (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire [lsf_pkg::CHAR_W-1:0]        s_axis_tdata_i,   // [7:0] char_code
  input  wire [lsf_pkg::OP_W-1:0]          s_axis_tuser_i,   // [1:0] opcode
  output logic                             m_axis_tvalid_o,
  input  wire                              m_axis_tready_i,
  output logic [lsf_pkg::OUT_W-1:0]        m_axis_tdata_o    // [9:0] start_position,
                                                             // [19:10] end_position, [23:20] 0
);
  import lsf_pkg::*;

  logic             fq_valid, fq_ready;
  cmd_t             fq_cmd;
  logic             qb_valid, qb_ready;
  cmd_t             qb_cmd;
  logic [POS_W-1:0] res_start, res_end;

  lsf_front u_front (
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .opcode_i    (s_axis_tuser_i),
    .char_code_i (s_axis_tdata_i),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready),
    .cmd_o       (fq_cmd)
  );

  lsf_fifo u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_cmd),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_cmd)
  );

  lsf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (qb_valid),
    .cmd_ready_o (qb_ready),
    .cmd_i       (qb_cmd),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_start_o (res_start),
    .out_end_o   (res_end)
  );

  assign m_axis_tdata_o = {(OUT_W - 2 * POS_W)'(0), res_end, res_start};

endmodule
`default_nettype wire

### verif/tb_letter_sum_substring_finder.sv
// Testbench for the letter-sum substring finder: stream driver, monitor and match predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_letter_sum_substring_finder;
  import lsf_pkg::*;

  typedef enum int {
    TR_STEADY,
    TR_SRC_GAPS,
    TR_SNK_STALLS,
    TR_BOTH
  } traffic_e;

  typedef struct {
    opcode_e    op;
    logic [7:0] ch;
    traffic_e   mode;
    bit         hold;
  } feed_t;

  typedef struct {
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] last_pos;
  } match_t;

  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [CHAR_W-1:0] s_axis_tdata = '0;   // [7:0] char_code
  logic [OP_W-1:0]   s_axis_tuser = '0;   // [1:0] opcode
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;       // [9:0] start_position, [19:10] end_position

  letter_sum_substring_finder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  feed_t  byte_feed[$];
  match_t pending_matches[$];
  feed_t  live_item;
  traffic_e plan_mode = TR_STEADY;
  traffic_e traffic_mode = TR_STEADY;
  logic   hold_kick = 1'b0;
  int unsigned hold_left = 0;
  int unsigned accepted_cnt = 0;
  int unsigned match_cnt = 0;
  int unsigned fail_cnt = 0;

  // Predictor state
  logic [SUM_W-1:0] goal_sum;
  int unsigned      acc_sum;
  logic [SUM_W-1:0] prefix_mem [TEXT_DEPTH];
  bit               letter_at  [TEXT_DEPTH];
  int unsigned      fill_len;
  int unsigned      open_start;

  function automatic int unsigned char_weight(input logic [7:0] c);
    if (c >= CH_UP_A && c <= CH_UP_Z) return c - CH_UP_A + 1;
    if (c >= CH_LO_A && c <= CH_LO_Z) return c - CH_LO_A + 1;
    return 0;
  endfunction

  // Advance the predicted block state by one accepted byte; queue a match if one closes.
  function automatic void find_next_match(input opcode_e op, input logic [7:0] ch);
    int unsigned w;
    int unsigned p;
    int unsigned s;
    int unsigned goal_wide;
    match_t hit;
    w = char_weight(ch);
    case (op)
      OP_CLEAR: begin
        goal_sum = '0;
        acc_sum = 0;
        fill_len = 0;
        open_start = 0;
      end
      OP_WORD: begin
        goal_wide = goal_sum + w;
        goal_sum = (goal_wide > SUM_MAX) ? SUM_MAX : goal_wide[SUM_W-1:0];
      end
      OP_TEXT: begin
        if (fill_len < TEXT_DEPTH) begin
          p = fill_len;
          prefix_mem[p] = acc_sum[SUM_W-1:0];
          letter_at[p] = (w != 0);
          acc_sum += w;
          fill_len = p + 1;
          s = open_start;
          while (s < fill_len && (!letter_at[s] || acc_sum - prefix_mem[s] > goal_sum)) s++;
          open_start = s;
          if (s < fill_len && letter_at[p] && acc_sum - prefix_mem[s] == goal_sum) begin
            hit.first_pos = s[POS_W-1:0];
            hit.last_pos = p[POS_W-1:0];
            pending_matches.push_back(hit);
            open_start = s + 1;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic push_feed(input opcode_e op, input logic [7:0] ch, input bit hold = 1'b0);
    feed_t f;
    f.op = op;
    f.ch = ch;
    f.mode = plan_mode;
    f.hold = hold;
    byte_feed.push_back(f);
  endtask

  function automatic logic [7:0] pick_letter(input bit narrow);
    int unsigned v;
    v = narrow ? $urandom_range(1, 5) : $urandom_range(1, 26);
    return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(v - 1);
  endfunction

  // Mostly clear, short word, then a text run; occasionally a continuation or noise.
  task automatic add_random_session();
    bit narrow;
    int unsigned k;
    narrow = $urandom_range(0, 1);
    if ($urandom_range(0, 99) < 85) push_feed(OP_CLEAR, 8'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 9) == 0) push_feed(OP_WORD, 8'($urandom_range(0, 255)));
      else push_feed(OP_WORD, pick_letter(narrow));
    end
    repeat ($urandom_range(8, 70)) begin
      k = $urandom_range(0, 99);
      if (k < 80) push_feed(OP_TEXT, pick_letter(narrow));
      else if (k < 91) push_feed(OP_TEXT, 8'($urandom_range(0, 255)));
      else if (k < 95) push_feed(OP_WORD, pick_letter(narrow));
      else if (k < 99) push_feed(OP_NONE, 8'($urandom_range(0, 255)));
      else push_feed(OP_CLEAR, 8'($urandom_range(0, 255)));
    end
  endtask

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin : p_drive
    logic next_valid;
    logic kick;
    int unsigned gap_pct;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= '0;
      hold_kick <= 1'b0;
      traffic_mode <= TR_STEADY;
    end else begin
      next_valid = s_axis_tvalid;
      kick = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        find_next_match(live_item.op, live_item.ch);
        accepted_cnt++;
        next_valid = 1'b0;
      end
      if (!next_valid && byte_feed.size() != 0) begin
        gap_pct = (byte_feed[0].mode == TR_SRC_GAPS) ? 86 :
                  (byte_feed[0].mode == TR_BOTH) ? 24 : 0;
        if ($urandom_range(0, 99) >= gap_pct) begin
          live_item = byte_feed.pop_front();
          next_valid = 1'b1;
          s_axis_tdata <= live_item.ch;
          s_axis_tuser <= live_item.op;
          traffic_mode <= live_item.mode;
          kick = live_item.hold;
        end
      end
      s_axis_tvalid <= next_valid;
      hold_kick <= kick;
    end
  end

  // Long receiver hold-off so the input side backs up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor
  always @(posedge clk_i or negedge rst_ni) begin : p_collect
    match_t want;
    int unsigned stall_pct;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        match_cnt++;
        if (pending_matches.size() == 0) begin
          $error("unexpected match transaction: start_position %0d, end_position %0d",
                 m_axis_tdata[9:0], m_axis_tdata[19:10]);
          fail_cnt++;
        end else begin
          want = pending_matches.pop_front();
          if (m_axis_tdata[9:0] !== want.first_pos) begin
            $error("start_position: expected %0d, actual %0d", want.first_pos, m_axis_tdata[9:0]);
            fail_cnt++;
          end
          if (m_axis_tdata[19:10] !== want.last_pos) begin
            $error("end_position: expected %0d, actual %0d", want.last_pos, m_axis_tdata[19:10]);
            fail_cnt++;
          end
        end
      end
      stall_pct = (traffic_mode == TR_SNK_STALLS) ? 86 : (traffic_mode == TR_BOTH) ? 24 : 0;
      m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin : p_main
    int unsigned total;
    int unsigned base;
    goal_sum = '0;
    acc_sum = 0;
    fill_len = 0;
    open_start = 0;

    // Directed: byte range edges, every opcode, zero and late targets
    push_feed(OP_NONE, 8'hFF);
    push_feed(OP_TEXT, 8'h41);    // target still zero
    push_feed(OP_CLEAR, 8'h00);
    push_feed(OP_WORD, 8'h5A);
    push_feed(OP_WORD, 8'h00);
    push_feed(OP_WORD, 8'h40);
    push_feed(OP_WORD, 8'h5B);
    push_feed(OP_WORD, 8'h60);
    push_feed(OP_WORD, 8'h7B);
    push_feed(OP_TEXT, 8'h60);
    push_feed(OP_TEXT, 8'h7A);
    push_feed(OP_TEXT, 8'h7B);
    push_feed(OP_TEXT, 8'h59);
    push_feed(OP_TEXT, 8'h41);
    push_feed(OP_WORD, 8'h61);    // word byte after text
    push_feed(OP_TEXT, 8'h6D);
    push_feed(OP_NONE, 8'h00);
    push_feed(OP_TEXT, 8'h20);
    push_feed(OP_TEXT, 8'h6E);
    push_feed(OP_CLEAR, 8'hFF);
    push_feed(OP_WORD, 8'h63);
    push_feed(OP_TEXT, 8'h61);
    push_feed(OP_TEXT, 8'h62);
    push_feed(OP_TEXT, 8'hFF);
    push_feed(OP_TEXT, 8'h80);

    // Every 'A' matches itself; the sink holds off while the source keeps pushing
    push_feed(OP_CLEAR, 8'h00);
    push_feed(OP_WORD, 8'h61);
    push_feed(OP_TEXT, 8'h41, 1'b1);
    repeat (40) push_feed(OP_TEXT, 8'h41);

    // Fill the text buffer past its end with frequent small matches
    push_feed(OP_CLEAR, 8'h00);
    push_feed(OP_WORD, 8'h43);
    repeat (1040) begin
      if ($urandom_range(0, 9) == 0) push_feed(OP_TEXT, 8'($urandom_range(0, 255)));
      else push_feed(OP_TEXT, 8'(CH_LO_A + $urandom_range(0, 2)));
    end
    push_feed(OP_WORD, 8'h61);
    repeat (5) push_feed(OP_TEXT, 8'h61);
    push_feed(OP_NONE, 8'h55);

    // Random sessions across four traffic phases
    base = byte_feed.size();
    while (byte_feed.size() - base < RANDOM_ITEMS) begin
      plan_mode = traffic_e'(((byte_feed.size() - base) * 4) / RANDOM_ITEMS);
      add_random_session();
    end
    total = byte_feed.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt != total) @(posedge clk_i);
    while (pending_matches.size() != 0) @(posedge clk_i);
    // a last text byte may still be stepping the start pointer
    repeat (2 * TEXT_DEPTH + 100) @(posedge clk_i);

    $display("covered %0d input transactions and %0d match transactions,", total, match_cnt);
    $display("incl. zero and late targets, a full text buffer and a long sink hold-off");
    if (fail_cnt == 0) begin
      $display("letter_sum_substring_finder regression: pass");
    end else begin
      $display("letter_sum_substring_finder regression: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("letter_sum_substring_finder regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
